// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    // Request codes carried in the low bits of the input transaction
    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_INS_POS   = 3'd2,
        REQ_DEL_FRONT = 3'd3,
        REQ_DEL_BACK  = 3'd4,
        REQ_DEL_POS   = 3'd5,
        REQ_SEARCH    = 3'd6
    } req_t;

    // Result status codes
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_EMPTY    = 3'd1,
        STS_BADPOS   = 3'd2,
        STS_FULL     = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    // Kind of memory work a request needs
    typedef enum logic [1:0] {
        OP_NONE,
        OP_UP,
        OP_DOWN,
        OP_SEARCH
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SWEEP,
        S_TAIL,
        S_PUT,
        S_DONE
    } ctl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic put;
        logic finish;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  kind;
        logic noshift;
        logic last;
        logic out_free;
    } dp_stat_t;

    // Field layout of the stream payloads
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 56;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int CODE_W   = 3;

endpackage

// ===== rtl/ple_ctrl.sv =====
module ple_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ple_pkg::dp_stat_t stat,
    output ple_pkg::ctl_cmd_t cmd
);

    ple_pkg::ctl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ple_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ple_pkg::S_IDLE: begin
                // hold the input closed while reset is asserted
                s_tready = aresetn;
                if (aresetn && s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ple_pkg::S_START;
                end
            end
            ple_pkg::S_START: begin
                case (stat.kind)
                    ple_pkg::OP_NONE:   state_next = ple_pkg::S_DONE;
                    ple_pkg::OP_UP:     state_next = stat.noshift ? ple_pkg::S_PUT
                                                                  : ple_pkg::S_SWEEP;
                    default:            state_next = ple_pkg::S_SWEEP;
                endcase
            end
            ple_pkg::S_SWEEP: begin
                // issue one read per cycle until the last address
                cmd.rd = 1'b1;
                if (stat.last) begin
                    state_next = ple_pkg::S_TAIL;
                end
            end
            ple_pkg::S_TAIL: begin
                // last read data is consumed by the datapath here
                state_next = (stat.kind == ple_pkg::OP_UP) ? ple_pkg::S_PUT
                                                           : ple_pkg::S_DONE;
            end
            ple_pkg::S_PUT: begin
                cmd.put    = 1'b1;
                state_next = ple_pkg::S_DONE;
            end
            ple_pkg::S_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ple_dp.sv =====
module ple_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ple_pkg::M_DATA_W-1:0]  m_tdata,
    input  ple_pkg::ctl_cmd_t             cmd,
    output ple_pkg::dp_stat_t             stat
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
    localparam int VW = ple_pkg::VAL_W;
    localparam int PAD_W = ple_pkg::M_DATA_W - ple_pkg::CODE_W - VW - 2 * ple_pkg::POS_W;

    // Entry store
    logic [VW-1:0] entries_mem [CAPACITY];

    // Control registers
    logic [CW-1:0] occ_reg;
    logic          rv_reg;
    logic          m_tvalid_reg;

    // Request and sweep registers
    ple_pkg::op_t     kind_reg;
    ple_pkg::status_t st_reg;
    logic [VW-1:0]    val_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    last_reg;
    logic [AW-1:0]    tag_reg;
    logic             noshift_reg;
    logic             rfirst_reg;
    logic             found_reg;
    logic [CW-1:0]    fpos_reg;
    logic [VW-1:0]    rdata_reg;
    logic [VW-1:0]    rval_reg;
    logic [ple_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Input fields
    logic [ple_pkg::CODE_W-1:0] in_req;
    logic [VW-1:0]              in_val;
    logic [ple_pkg::POS_W-1:0]  in_pos;

    assign in_req = s_tdata[2:0];
    assign in_val = s_tdata[34:3];
    assign in_pos = s_tdata[41:35];

    // Request decode against the current count
    ple_pkg::op_t     dec_kind;
    ple_pkg::status_t dec_st;
    logic [PW-1:0]    nw;
    logic [PW-1:0]    posw;
    logic [PW-1:0]    idx_w;
    logic             full;
    logic             empty;

    always_comb begin
        nw       = PW'(occ_reg);
        posw     = PW'(in_pos);
        full     = (nw == PW'(CAPACITY));
        empty    = (occ_reg == '0);
        dec_kind = ple_pkg::OP_NONE;
        dec_st   = ple_pkg::STS_OK;
        idx_w    = '0;
        case (in_req)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_BACK, ple_pkg::REQ_INS_POS: begin
                if (full) begin
                    dec_st = ple_pkg::STS_FULL;
                end else if (in_req == ple_pkg::REQ_INS_FRONT) begin
                    dec_kind = ple_pkg::OP_UP;
                end else if (in_req == ple_pkg::REQ_INS_BACK) begin
                    dec_kind = ple_pkg::OP_UP;
                    idx_w    = nw;
                end else if (posw == '0 || posw > nw + PW'(1)) begin
                    dec_st = ple_pkg::STS_BADPOS;
                end else begin
                    dec_kind = ple_pkg::OP_UP;
                    idx_w    = posw - PW'(1);
                end
            end
            ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_BACK, ple_pkg::REQ_DEL_POS: begin
                if (empty) begin
                    dec_st = ple_pkg::STS_EMPTY;
                end else if (in_req == ple_pkg::REQ_DEL_FRONT) begin
                    dec_kind = ple_pkg::OP_DOWN;
                end else if (in_req == ple_pkg::REQ_DEL_BACK) begin
                    dec_kind = ple_pkg::OP_DOWN;
                    idx_w    = nw - PW'(1);
                end else if (posw == '0 || posw > nw) begin
                    dec_st = ple_pkg::STS_BADPOS;
                end else begin
                    dec_kind = ple_pkg::OP_DOWN;
                    idx_w    = posw - PW'(1);
                end
            end
            ple_pkg::REQ_SEARCH: begin
                if (empty) begin
                    dec_st = ple_pkg::STS_EMPTY;
                end else begin
                    dec_kind = ple_pkg::OP_SEARCH;
                end
            end
            default: begin
                dec_kind = ple_pkg::OP_NONE;
            end
        endcase
    end

    // Latch the request and set up the sweep
    logic [AW-1:0] nm1;
    assign nm1 = AW'(nw - PW'(1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= dec_kind;
            st_reg      <= dec_st;
            val_reg     <= in_val;
            idx_reg     <= idx_w[AW-1:0];
            noshift_reg <= (idx_w == nw);
            rfirst_reg  <= 1'b1;
            found_reg   <= 1'b0;
            fpos_reg    <= '0;
            case (dec_kind)
                ple_pkg::OP_UP: begin
                    ptr_reg  <= nm1;
                    last_reg <= idx_w[AW-1:0];
                end
                ple_pkg::OP_DOWN: begin
                    ptr_reg  <= idx_w[AW-1:0];
                    last_reg <= nm1;
                end
                default: begin
                    ptr_reg  <= '0;
                    last_reg <= nm1;
                end
            endcase
        end else begin
            // advance the read pointer
            if (cmd.rd) begin
                ptr_reg <= (kind_reg == ple_pkg::OP_UP) ? ptr_reg - AW'(1)
                                                        : ptr_reg + AW'(1);
                tag_reg <= ptr_reg;
            end
            // consume read data
            if (rv_reg) begin
                rfirst_reg <= 1'b0;
                if (rfirst_reg) begin
                    rval_reg <= rdata_reg;
                end
                if (kind_reg == ple_pkg::OP_SEARCH && !found_reg
                    && rdata_reg == val_reg) begin
                    found_reg <= 1'b1;
                    fpos_reg  <= CW'(tag_reg) + CW'(1);
                end
            end
        end
    end

    // Read data valid tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg <= 1'b0;
        end else begin
            rv_reg <= cmd.rd;
        end
    end

    // Memory write: shifted entries or the new value
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = tag_reg;
        wr_data = rdata_reg;
        if (cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = idx_reg;
            wr_data = val_reg;
        end else if (rv_reg && kind_reg == ple_pkg::OP_UP) begin
            wr_en   = 1'b1;
            wr_addr = tag_reg + AW'(1);
        end else if (rv_reg && kind_reg == ple_pkg::OP_DOWN && !rfirst_reg) begin
            wr_en   = 1'b1;
            wr_addr = tag_reg - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rdata_reg <= entries_mem[ptr_reg];
        end
    end

    // Result assembly
    ple_pkg::status_t res_st;
    logic [VW-1:0]    res_val;
    logic [PW-1:0]    res_pos_w;
    logic [CW-1:0]    occ_next;
    logic [PW-1:0]    cnt_w;

    always_comb begin
        res_st    = st_reg;
        res_val   = '0;
        res_pos_w = '0;
        occ_next  = occ_reg;
        case (kind_reg)
            ple_pkg::OP_UP: begin
                occ_next = occ_reg + CW'(1);
            end
            ple_pkg::OP_DOWN: begin
                occ_next = occ_reg - CW'(1);
                res_val  = rval_reg;
            end
            ple_pkg::OP_SEARCH: begin
                if (found_reg) begin
                    res_st    = ple_pkg::STS_OK;
                    res_val   = val_reg;
                    res_pos_w = PW'(fpos_reg);
                end else begin
                    res_st = ple_pkg::STS_NOTFOUND;
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
        cnt_w = PW'(occ_next);
    end

    // Count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            occ_reg      <= occ_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {PAD_W'(0), cnt_w[ple_pkg::POS_W-1:0],
                            res_pos_w[ple_pkg::POS_W-1:0], res_val, res_st};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.kind     = kind_reg;
    assign stat.noshift  = noshift_reg;
    assign stat.last     = (ptr_reg == last_reg);
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== rtl/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit values, one request per input
// transaction and exactly one result transaction per request. Requests are
// handled one at a time; the entries sit in a memory with one write and one
// registered read port, and a request sweeps the entries that move, or that
// a search visits, one after another through that port. An insert reads the
// entries behind the insert point (none when it lands at the back), a delete
// the entries from the delete point to the back, and a search the whole list;
// a refused request or request code 7 reads none. A finished result waits in
// the output register and does not block the next request from starting.
// The list is empty after reset, with no clearing pass.
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[2:0], item_value[34:3], position[41:35], zeros above
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[2:0], result_value[34:3], result_position[41:35],
    // entry_count[48:42], zeros above
    output logic [55:0] m_tdata
);

    ple_pkg::ctl_cmd_t cmd;
    ple_pkg::dp_stat_t stat;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== rtl/ple_checker.sv =====
module ple_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] outstanding_reg;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Track requests accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else if (in_acc && !out_acc) begin
            outstanding_reg <= outstanding_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            outstanding_reg <= outstanding_reg - 2'd1;
        end
    end

    // A result is shown only for a request that was accepted
    a_no_orphan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> outstanding_reg != 2'd0)
        else $error("result without an accepted request");

    // One request at a time: input closes right after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input accepted twice in a row");

    // An empty-list refusal reports an empty list, no value and no position
    a_empty_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == ple_pkg::STS_EMPTY |->
            m_tdata[48:42] == 7'd0 && m_tdata[34:3] == 32'd0 && m_tdata[41:35] == 7'd0)
        else $error("empty status with nonzero fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
